// ----- rtl/tmot_pkg.sv -----
`default_nettype none
package tmot_pkg;

    localparam int TIME_W         = 64;
    localparam int ID_W           = 4;
    localparam int CNT_W          = 5;
    localparam int ACTIVE_W       = 5;
    localparam int CMD_W          = 2;
    localparam int S_TUSER_W      = CMD_W + 1;
    localparam int M_TDATA_W      = 80;
    localparam int DEF_MAX_QUEUES = 16;

    localparam logic [TIME_W-1:0] EMPTY_KEY = '1;

    localparam logic [CMD_W-1:0] CMD_RELOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REFILL  = 2'd2;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } tmot_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/tmot_table.sv -----
`default_nettype none
module tmot_table import tmot_pkg::*; #(
    parameter int MAX_QUEUES = DEF_MAX_QUEUES,
    parameter int AW         = $clog2(MAX_QUEUES)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tmot_ctl_t         ctl,
    input  wire logic [AW-1:0]     rd_addr,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [TIME_W-1:0] wr_key,
    input  wire logic [ID_W-1:0]   wr_id,
    output logic      [TIME_W-1:0] rd_key,
    output logic      [ID_W-1:0]   rd_id
);

    logic [TIME_W-1:0]     key_mem [MAX_QUEUES];
    logic [ID_W-1:0]       id_mem  [MAX_QUEUES];
    logic [MAX_QUEUES-1:0] vld_reg;

    logic [TIME_W-1:0] rd_key_reg;
    logic [ID_W-1:0]   rd_id_reg;
    logic              rd_vld_reg;
    logic [AW-1:0]     rd_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ctl.clear) begin
            vld_reg <= '0;
        end else if (ctl.wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            key_mem[wr_addr] <= wr_key;
            id_mem[wr_addr]  <= wr_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_id_reg   <= id_mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // An entry never written since the last reload reads as empty, holding its own index.
    assign rd_key = rd_vld_reg ? rd_key_reg : EMPTY_KEY;
    assign rd_id  = rd_vld_reg ? rd_id_reg : ID_W'(rd_addr_reg);

endmodule
`default_nettype wire

// ----- rtl/timestamp_merge_order_table_top.sv -----
`default_nettype none
// Reload and the unused command go straight to reading the head and tail entries; advance
// and refill first check the entry and, when the table holds more than one, move it one
// position per compare step until it is in order.
// Items are handled one at a time: the next transfer is taken the cycle after the result is
// registered, and a result not yet taken by the output holds off the next one.
// Reset (aresetn, synchronous, active low) empties the table, gives entry i id i
// and sets the active count and the register to one.
module timestamp_merge_order_table_top import tmot_pkg::*; #(
    parameter int MAX_QUEUES = DEF_MAX_QUEUES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wen,
    input  wire logic [ACTIVE_W-1:0]  cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [TIME_W-1:0]    s_tdata,   // new_time
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // cmd, new_ready
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // head_queue, head_time, tail_queue, empty_count
    output logic                      m_tuser    // head_valid
);

    localparam int AW = $clog2(MAX_QUEUES);
    localparam int CW = $clog2(MAX_QUEUES + 1);
    localparam int LW = (CW > ACTIVE_W) ? CW : ACTIVE_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV_CHK,
        ST_SINK_CMP,
        ST_SINK_PUT,
        ST_REF_CHK,
        ST_RISE_CMP,
        ST_RISE_PUT,
        ST_HEAD_RD,
        ST_HEAD_CAP,
        ST_TAIL_CAP,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [ACTIVE_W-1:0]  active_reg;
    logic [CW-1:0]        live_reg;
    logic [CW-1:0]        empty_reg;
    logic [AW-1:0]        pos_reg;
    logic [TIME_W-1:0]    key_reg;
    logic [ID_W-1:0]      cur_id_reg;
    logic [TIME_W-1:0]    head_key_reg;
    logic [ID_W-1:0]      head_id_reg;
    logic [ID_W-1:0]      tail_id_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    tmot_ctl_t         ctl;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [TIME_W-1:0] wr_key;
    logic [ID_W-1:0]   wr_id;
    logic [TIME_W-1:0] rd_key;
    logic [ID_W-1:0]   rd_id;

    logic              accept;
    logic [CMD_W-1:0]  in_cmd;
    logic [TIME_W-1:0] in_key;
    logic [AW-1:0]     live_last;
    logic              multi;
    logic              sink_more;
    logic              rise_more;
    logic [LW-1:0]     act_ext;
    logic [CW-1:0]     live_load;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_cmd    = s_tuser[CMD_W-1:0];
    assign in_key    = s_tuser[CMD_W] ? s_tdata : EMPTY_KEY;
    assign live_last = AW'(live_reg - CW'(1));
    assign multi     = (live_reg > CW'(1));
    assign sink_more = ((CW+1)'(pos_reg) + (CW+1)'(2)) < (CW+1)'(live_reg);
    assign rise_more = (pos_reg > AW'(1));
    assign act_ext   = LW'(active_reg);

    always_comb begin
        if (act_ext == '0) begin
            live_load = CW'(1);
        end else if (act_ext > LW'(MAX_QUEUES)) begin
            live_load = CW'(MAX_QUEUES);
        end else begin
            live_load = CW'(act_ext);
        end
    end

    always_comb begin
        ctl     = '0;
        rd_addr = '0;
        wr_addr = pos_reg;
        wr_key  = key_reg;
        wr_id   = cur_id_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_RELOAD:  ctl.clear = 1'b1;
                        CMD_ADVANCE: ctl.rd_en = 1'b1;
                        CMD_REFILL: begin
                            ctl.rd_en = 1'b1;
                            rd_addr   = live_last;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADV_CHK: begin
                if (rd_key != EMPTY_KEY) begin
                    if (multi) begin
                        ctl.rd_en = 1'b1;
                        rd_addr   = AW'(1);
                    end else begin
                        ctl.wr_en = 1'b1;
                        wr_addr   = '0;
                        wr_id     = rd_id;
                    end
                end
            end
            ST_SINK_CMP: begin
                ctl.wr_en = 1'b1;
                if (key_reg > rd_key) begin
                    wr_key = rd_key;
                    wr_id  = rd_id;
                    if (sink_more) begin
                        ctl.rd_en = 1'b1;
                        rd_addr   = pos_reg + AW'(2);
                    end
                end
            end
            ST_REF_CHK: begin
                if (rd_key == EMPTY_KEY) begin
                    if (multi) begin
                        ctl.rd_en = 1'b1;
                        rd_addr   = live_last - AW'(1);
                    end else begin
                        ctl.wr_en = 1'b1;
                        wr_addr   = live_last;
                        wr_id     = rd_id;
                    end
                end
            end
            ST_RISE_CMP: begin
                ctl.wr_en = 1'b1;
                if (key_reg <= rd_key) begin
                    wr_key = rd_key;
                    wr_id  = rd_id;
                    if (rise_more) begin
                        ctl.rd_en = 1'b1;
                        rd_addr   = pos_reg - AW'(2);
                    end
                end
            end
            ST_SINK_PUT, ST_RISE_PUT: ctl.wr_en = 1'b1;
            ST_HEAD_RD:  ctl.rd_en = 1'b1;
            ST_HEAD_CAP: begin
                ctl.rd_en = 1'b1;
                rd_addr   = live_last;
            end
            default: ;
        endcase
    end

    tmot_table #(
        .MAX_QUEUES (MAX_QUEUES),
        .AW         (AW)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_id   (wr_id),
        .rd_key  (rd_key),
        .rd_id   (rd_id)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_W'(1);
        end else if (cfg_wen) begin
            active_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            live_reg     <= CW'(1);
            empty_reg    <= CW'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        key_reg <= in_key;
                        case (in_cmd)
                            CMD_RELOAD: begin
                                live_reg  <= live_load;
                                empty_reg <= live_load;
                                state_reg <= ST_HEAD_RD;
                            end
                            CMD_ADVANCE: state_reg <= ST_ADV_CHK;
                            CMD_REFILL:  state_reg <= ST_REF_CHK;
                            default:     state_reg <= ST_HEAD_RD;
                        endcase
                    end
                end
                ST_ADV_CHK: begin
                    state_reg <= ST_HEAD_RD;
                    if (rd_key != EMPTY_KEY) begin
                        pos_reg    <= '0;
                        cur_id_reg <= rd_id;
                        if (key_reg == EMPTY_KEY) begin
                            empty_reg <= empty_reg + CW'(1);
                        end
                        if (multi) begin
                            state_reg <= ST_SINK_CMP;
                        end
                    end
                end
                ST_SINK_CMP: begin
                    if (key_reg > rd_key) begin
                        pos_reg   <= pos_reg + AW'(1);
                        state_reg <= sink_more ? ST_SINK_CMP : ST_SINK_PUT;
                    end else begin
                        state_reg <= ST_HEAD_RD;
                    end
                end
                ST_REF_CHK: begin
                    state_reg <= ST_HEAD_RD;
                    if (rd_key == EMPTY_KEY) begin
                        pos_reg    <= live_last;
                        cur_id_reg <= rd_id;
                        if (key_reg != EMPTY_KEY) begin
                            empty_reg <= empty_reg - CW'(1);
                        end
                        if (multi) begin
                            state_reg <= ST_RISE_CMP;
                        end
                    end
                end
                ST_RISE_CMP: begin
                    if (key_reg <= rd_key) begin
                        pos_reg   <= pos_reg - AW'(1);
                        state_reg <= rise_more ? ST_RISE_CMP : ST_RISE_PUT;
                    end else begin
                        state_reg <= ST_HEAD_RD;
                    end
                end
                ST_SINK_PUT, ST_RISE_PUT: state_reg <= ST_HEAD_RD;
                ST_HEAD_RD:  state_reg <= ST_HEAD_CAP;
                ST_HEAD_CAP: begin
                    head_key_reg <= rd_key;
                    head_id_reg  <= rd_id;
                    state_reg    <= ST_TAIL_CAP;
                end
                ST_TAIL_CAP: begin
                    tail_id_reg <= rd_id;
                    state_reg   <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {3'b000, CNT_W'(empty_reg), tail_id_reg,
                                         head_key_reg, head_id_reg};
                        m_tuser_reg  <= (head_key_reg != EMPTY_KEY);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_head_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == (m_tdata[67:4] != EMPTY_KEY)))
        else $error("Head valid flag disagrees with the head key.");

    a_empty_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg <= live_reg)
        else $error("Empty count exceeds the active count.");

    a_live_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (live_reg != '0) && (live_reg <= CW'(MAX_QUEUES)))
        else $error("Active count out of range.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("A transfer was taken while another item is in progress.");

endmodule
`default_nettype wire
